// File: hdl/bis_pkg.sv
// Shared types and constants for the bucketed signed 32-bit key search.
// Used by bis_ctrl, bis_dp and bucketed_int32_key_search.
// No dependencies.
package bis_pkg;

	// Field widths of the transaction payloads.
	localparam int OP_W     = 2;
	localparam int KEY_W    = 32;
	localparam int ADDR_W   = 16;
	localparam int STATUS_W = 2;
	localparam int IDX_W    = 12;
	localparam int CNT_W    = 13;
	localparam int DIR_W    = 13;
	localparam int BUCKET_W = 16;

	// Default value table depth.
	localparam int TABLE_DEPTH_DEF = 4096;

	// Directory entries saturate to the largest 13-bit start.
	localparam logic [DIR_W-1:0] DIR_MAX = 13'h1FFF;

	// Bucket number is the key's top half with its sign bit flipped.
	localparam logic [BUCKET_W-1:0] BUCKET_FLIP = 16'h8000;
	localparam logic [BUCKET_W-1:0] LAST_BUCKET = 16'hFFFF;
	localparam int                  KEY_SHIFT   = 16;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_QUERY    = 2'd0;
	localparam logic [OP_W-1:0] OP_WR_VALUE = 2'd1;
	localparam logic [OP_W-1:0] OP_WR_DIR   = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                accept;
		logic                dir_rd_bucket;
		logic                dir_rd_next;
		logic                start_load;
		logic                range_load;
		logic                scan_en;
		logic                val_wr;
		logic                dir_wr;
		logic                res_set;
		logic [STATUS_W-1:0] res_status;
		logic                res_found;
		logic                out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            count_zero;
		logic            addr_ok;
		logic            last_bucket;
		logic            range_empty;
		logic            hit;
		logic            scan_over;
		logic            out_free;
	} sts_t;

endpackage

// File: hdl/bucketed_int32_key_search.sv
// Bucketed signed 32-bit key search. Items run one at a time. A query with a
// nonzero count reads its bucket's directory entry and, unless it is the last
// bucket, the next bucket's entry, then scans any non-empty range, reading one
// value table entry per cycle from its single read port. The result sits in an
// output register, so a finished result can wait on a stalled receiver while
// the controller holds the next transaction. The user must write table_count
// through cfg_wr_en and cfg_wr_data only while no transaction is in flight;
// the block itself does not enforce this. Table and directory entries must be
// written before queries read them; they have no reset value.
// Depends on bis_pkg, bis_ctrl and bis_dp.
module bucketed_int32_key_search #(
	parameter int TABLE_DEPTH = bis_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bis_pkg::OP_W-1:0]          op,
	input  logic signed [bis_pkg::KEY_W-1:0]  key,
	input  logic [bis_pkg::ADDR_W-1:0]        address,
	input  logic signed [bis_pkg::KEY_W-1:0]  write_data,
	input  logic                              cfg_wr_en,
	input  logic [bis_pkg::CNT_W-1:0]         cfg_wr_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bis_pkg::STATUS_W-1:0]      status,
	output logic [bis_pkg::IDX_W-1:0]         found_index
);

	bis_pkg::cmd_t cmd;
	bis_pkg::sts_t sts;

	// Controller.
	bis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath with the value table and directory.
	bis_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.key         (key),
		.address     (address),
		.write_data  (write_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.found_index (found_index)
	);

endmodule

// File: hdl/bis_ctrl.sv
// Controller state machine for the bucketed key search.
// Sequences decode, directory reads, the bucket scan and the response.
// Depends on bis_pkg.
module bis_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  bis_pkg::sts_t sts,
	output bis_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_DIR_A  = 3'd2;
	localparam logic [2:0] S_DIR_B  = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_RESP   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// A new transaction is taken only between items.
	assign in_stall = (state_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				state_nxt = S_RESP;
				cmd.res_set = 1'b1;
				unique case (sts.op)
					bis_pkg::OP_QUERY: begin
						if (sts.count_zero) begin
							cmd.res_status = bis_pkg::ST_INVALID;
						end else begin
							cmd.res_set = 1'b0;
							cmd.dir_rd_bucket = 1'b1;
							state_nxt = S_DIR_A;
						end
					end
					bis_pkg::OP_WR_VALUE: begin
						cmd.val_wr = sts.addr_ok;
						cmd.res_status = sts.addr_ok ? bis_pkg::ST_OK : bis_pkg::ST_INVALID;
					end
					bis_pkg::OP_WR_DIR: begin
						cmd.dir_wr = 1'b1;
						cmd.res_status = bis_pkg::ST_OK;
					end
					default: begin
						cmd.res_status = bis_pkg::ST_INVALID;
					end
				endcase
			end
			S_DIR_A: begin
				// Start of the bucket is back; fetch the next bucket's start unless this is the last bucket.
				cmd.start_load = 1'b1;
				cmd.dir_rd_next = !sts.last_bucket;
				state_nxt = S_DIR_B;
			end
			S_DIR_B: begin
				if (sts.range_empty) begin
					cmd.res_set = 1'b1;
					cmd.res_status = bis_pkg::ST_NOT_FOUND;
					state_nxt = S_RESP;
				end else begin
					cmd.range_load = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.hit) begin
					cmd.res_set = 1'b1;
					cmd.res_status = bis_pkg::ST_OK;
					cmd.res_found = 1'b1;
					state_nxt = S_RESP;
				end else if (sts.scan_over) begin
					cmd.res_set = 1'b1;
					cmd.res_status = bis_pkg::ST_NOT_FOUND;
					state_nxt = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: hdl/bis_dp.sv
// Datapath for the bucketed key search: value table, bucket directory,
// item and range registers, scan compare and the output register.
// Depends on bis_pkg.
module bis_dp #(
	parameter int TABLE_DEPTH = bis_pkg::TABLE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bis_pkg::cmd_t                      cmd,
	output bis_pkg::sts_t                      sts,
	input  logic [bis_pkg::OP_W-1:0]           op,
	input  logic signed [bis_pkg::KEY_W-1:0]   key,
	input  logic [bis_pkg::ADDR_W-1:0]         address,
	input  logic signed [bis_pkg::KEY_W-1:0]   write_data,
	input  logic                               cfg_wr_en,
	input  logic [bis_pkg::CNT_W-1:0]          cfg_wr_data,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [bis_pkg::STATUS_W-1:0]       status,
	output logic [bis_pkg::IDX_W-1:0]          found_index
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = bis_pkg::CNT_W;
	localparam int DW = bis_pkg::DIR_W;
	localparam int KW = bis_pkg::KEY_W;
	localparam int BW = bis_pkg::BUCKET_W;
	localparam int RW = bis_pkg::ADDR_W;
	localparam int IW = bis_pkg::IDX_W;
	localparam int BUCKETS = 1 << BW;
	localparam int unsigned DEPTH_CAP =
		(TABLE_DEPTH > int'(bis_pkg::DIR_MAX)) ? int'(bis_pkg::DIR_MAX) : TABLE_DEPTH;
	localparam logic [CW-1:0] COUNT_CAP = CW'(DEPTH_CAP);

	// Memories.
	logic [KW-1:0] value_mem [TABLE_DEPTH];
	logic [DW-1:0] dir_mem   [BUCKETS];

	// Item registers.
	logic [bis_pkg::OP_W-1:0] op_q;
	logic [KW-1:0]            key_q;
	logic [RW-1:0]            addr_q;
	logic [KW-1:0]            wdata_q;

	logic [CW-1:0] table_count_q;
	logic [CW-1:0] count_act;

	logic [DW-1:0] dir_rdata_q;
	logic [KW-1:0] value_rdata_s1;
	logic [DW-1:0] start_q;
	logic [DW-1:0] end_q;
	logic [CW-1:0] scan_q;
	logic [CW-1:0] cmp_idx_s1;
	logic          cmp_vld_s1;

	logic [bis_pkg::STATUS_W-1:0] res_status_q;
	logic [IW-1:0]                res_index_q;
	logic                         out_valid_q;
	logic [bis_pkg::STATUS_W-1:0] status_q;
	logic [IW-1:0]                found_index_q;

	logic [BW-1:0]    bucket;
	logic [BW-1:0]    dir_rd_addr;
	logic [DW-1:0]    dir_sat;
	logic [DW-1:0]    end_raw;
	logic [AW+RW-1:0] wr_wide;
	logic [AW+CW-1:0] rd_wide;
	logic [AW-1:0]    val_wr_addr;
	logic [AW-1:0]    val_rd_addr;
	logic             scan_issue;

	// Count in use is the register saturated to the table depth, capped at DIR_MAX.
	assign count_act = (table_count_q > COUNT_CAP) ? COUNT_CAP : table_count_q;

	// Bucket of the key and directory read address.
	assign bucket      = key_q[KW-1 -: BW] ^ bis_pkg::BUCKET_FLIP;
	assign dir_rd_addr = cmd.dir_rd_next ? (bucket + BW'(1)) : bucket;

	// Directory writes saturate into the 13-bit store.
	always_comb begin
		if (wdata_q[KW-1]) begin
			dir_sat = '0;
		end else if (|wdata_q[KW-2:DW]) begin
			dir_sat = bis_pkg::DIR_MAX;
		end else begin
			dir_sat = wdata_q[DW-1:0];
		end
	end

	// End of range: next bucket's start, or the count for the last bucket.
	assign end_raw = (bucket == bis_pkg::LAST_BUCKET) ? count_act : dir_rdata_q;

	// Value table addresses.
	assign wr_wide     = {AW'(0), addr_q};
	assign val_wr_addr = wr_wide[AW-1:0];
	assign rd_wide     = {AW'(0), scan_q};
	assign val_rd_addr = rd_wide[AW-1:0];
	assign scan_issue  = cmd.scan_en && (scan_q < end_q);

	// Status toward the controller.
	assign sts.op          = op_q;
	assign sts.count_zero  = (count_act == '0);
	assign sts.addr_ok     = (32'(addr_q) < 32'(TABLE_DEPTH));
	assign sts.last_bucket = (bucket == bis_pkg::LAST_BUCKET);
	assign sts.range_empty = (start_q >= end_raw);
	assign sts.hit         = cmp_vld_s1 && (value_rdata_s1 == key_q);
	assign sts.scan_over   = !cmp_vld_s1 && (scan_q >= end_q);
	assign sts.out_free    = !out_valid_q || !out_stall;

	// Value table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.val_wr) begin
			value_mem[val_wr_addr] <= wdata_q;
		end
		if (scan_issue) begin
			value_rdata_s1 <= value_mem[val_rd_addr];
		end
	end

	// Bucket directory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.dir_wr) begin
			dir_mem[addr_q] <= dir_sat;
		end
		if (cmd.dir_rd_bucket || cmd.dir_rd_next) begin
			dir_rdata_q <= dir_mem[dir_rd_addr];
		end
	end

	// Item capture, range setup and scan index.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= op;
			key_q   <= key;
			addr_q  <= address;
			wdata_q <= write_data;
		end
		if (cmd.start_load) begin
			start_q <= dir_rdata_q;
		end
		if (cmd.range_load) begin
			end_q  <= (end_raw > count_act) ? count_act : end_raw;
			scan_q <= start_q;
		end else if (scan_issue) begin
			scan_q <= scan_q + CW'(1);
		end
		if (scan_issue) begin
			cmp_idx_s1 <= scan_q;
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			res_index_q  <= cmd.res_found ? cmp_idx_s1[IW-1:0] : '0;
		end
		if (cmd.out_load) begin
			status_q      <= res_status_q;
			found_index_q <= res_index_q;
		end
	end

	// Control registers: table count, compare valid and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_count_q <= '0;
			cmp_vld_s1    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				table_count_q <= cfg_wr_data;
			end
			cmp_vld_s1 <= scan_issue;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_index_q;

endmodule

// File: verif/tb_bucketed_int32_key_search.sv
// Self-checking testbench for bucketed_int32_key_search: loads table and directory entries,
// runs key searches under varied traffic and checks every answer in order against a predictor.
// Depends on bis_pkg and the bucketed_int32_key_search RTL.
`timescale 1ns / 1ps

module tb_bucketed_int32_key_search;
	import bis_pkg::*;

	// The package has no name for the fourth opcode, which the block rejects.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int BUCKETS = 65536;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic signed [KEY_W-1:0] key;
		logic [ADDR_W-1:0]       addr;
		logic signed [KEY_W-1:0] data;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    index;
	} answer_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [OP_W-1:0]         op = '0;
	logic signed [KEY_W-1:0] key = '0;
	logic [ADDR_W-1:0]       address = '0;
	logic signed [KEY_W-1:0] write_data = '0;
	logic                    cfg_wr_en = 1'b0;
	logic [CNT_W-1:0]        cfg_wr_data = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [STATUS_W-1:0]     status;
	logic [IDX_W-1:0]        found_index;

	// Traffic shaping for the current phase.
	int send_gap_pct = 0;
	int rx_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;

	request_t request_q[$];
	answer_t  expected_answers[$];
	int accepted_cnt = 0;
	int taken_seen = 0;
	int queued_cnt = 0;
	int error_cnt = 0;

	// Table state as the predictor sees it, updated at acceptance.
	logic [CNT_W-1:0]        table_count = '0;
	logic signed [KEY_W-1:0] shadow_values [TABLE_DEPTH_DEF];
	logic [DIR_W-1:0]        shadow_starts [BUCKETS];

	// What the stimulus has loaded so far, so that no search reads an unloaded entry.
	bit                      value_loaded [TABLE_DEPTH_DEF];
	bit                      start_loaded [BUCKETS];
	logic [DIR_W-1:0]        planned_starts [BUCKETS];
	logic [BUCKET_W-1:0]     live_buckets[$];
	logic signed [KEY_W-1:0] fresh_values[$];

	always #1 clk = ~clk;

	bucketed_int32_key_search u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.key        (key),
		.address    (address),
		.write_data (write_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.found_index(found_index)
	);

	// Bucket number: top half of the key with its sign bit flipped.
	function automatic logic [BUCKET_W-1:0] bucket_of(input logic signed [KEY_W-1:0] k);
		return k[KEY_W-1:KEY_SHIFT] ^ BUCKET_FLIP;
	endfunction

	// The count in use saturates at the table depth.
	function automatic int active_count();
		return (table_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(table_count);
	endfunction

	// Directory entries saturate into 0..DIR_MAX.
	function automatic logic [DIR_W-1:0] clip_start(input logic signed [KEY_W-1:0] d);
		if (d < 0)
			return '0;
		if (int'(d) > int'(DIR_MAX))
			return DIR_MAX;
		return d[DIR_W-1:0];
	endfunction

	// Works out the answer to one accepted transaction and applies its writes.
	function automatic answer_t predict_answer(input request_t r);
		answer_t             a;
		logic [BUCKET_W-1:0] b;
		int                  lo, hi, i, cnt;
		a.status = ST_OK;
		a.index = '0;
		cnt = active_count();
		case (r.op)
			OP_QUERY: begin
				if (cnt == 0) begin
					a.status = ST_INVALID;
				end else begin
					b = bucket_of(r.key);
					lo = int'(shadow_starts[b]);
					hi = (b != LAST_BUCKET) ? int'(shadow_starts[b + 1'b1]) : cnt;
					a.status = ST_NOT_FOUND;
					if (lo < hi) begin
						if (hi > cnt)
							hi = cnt;
						// Lowest matching index wins.
						i = lo;
						while (i < hi && a.status != ST_OK) begin
							if (shadow_values[i] == r.key) begin
								a.status = ST_OK;
								a.index = i[IDX_W-1:0];
							end
							i++;
						end
					end
				end
			end
			OP_WR_VALUE: begin
				if (r.addr < TABLE_DEPTH_DEF)
					shadow_values[r.addr] = r.data;
				else
					a.status = ST_INVALID;
			end
			OP_WR_DIR: begin
				shadow_starts[r.addr] = clip_start(r.data);
			end
			default: begin
				a.status = ST_INVALID;
			end
		endcase
		return a;
	endfunction

	// Queues one transaction and records what it will load.
	function automatic void push_request(input logic [OP_W-1:0] o,
			input logic signed [KEY_W-1:0] k, input logic [ADDR_W-1:0] ad,
			input logic signed [KEY_W-1:0] d);
		request_t r;
		r.op = o;
		r.key = k;
		r.addr = ad;
		r.data = d;
		request_q.push_back(r);
		queued_cnt++;
		if (o == OP_WR_VALUE && ad < TABLE_DEPTH_DEF)
			value_loaded[ad] = 1'b1;
		if (o == OP_WR_DIR) begin
			start_loaded[ad] = 1'b1;
			planned_starts[ad] = clip_start(d);
		end
	endfunction

	// A search may go out only if every directory entry and value it reads is loaded.
	function automatic bit query_safe(input logic signed [KEY_W-1:0] k);
		logic [BUCKET_W-1:0] b;
		int                  lo, hi, i, cnt;
		cnt = active_count();
		if (cnt == 0)
			return 1'b1;
		b = bucket_of(k);
		if (!start_loaded[b])
			return 1'b0;
		if (b != LAST_BUCKET && !start_loaded[b + 1'b1])
			return 1'b0;
		lo = int'(planned_starts[b]);
		hi = (b != LAST_BUCKET) ? int'(planned_starts[b + 1'b1]) : cnt;
		if (hi > cnt)
			hi = cnt;
		for (i = lo; i < hi; i++)
			if (!value_loaded[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void push_query(input logic signed [KEY_W-1:0] k);
		if (query_safe(k))
			push_request(OP_QUERY, k, ADDR_W'($urandom), $urandom);
	endfunction

	// Lays out one bucket: its directory range, then the values inside it.
	function automatic void build_bucket(input logic [BUCKET_W-1:0] b, input int lo,
			input int len);
		logic signed [KEY_W-1:0] v;
		int                      i;
		fresh_values.delete();
		push_request(OP_WR_DIR, $urandom, b, lo);
		if (b != LAST_BUCKET)
			push_request(OP_WR_DIR, $urandom, b + 1'b1, lo + len);
		v = {b ^ BUCKET_FLIP, 16'($urandom)};
		for (i = lo; i < lo + len; i++) begin
			// Repeat a value now and then so that the lowest index has to win.
			if (i == lo || $urandom_range(3) != 0)
				v = {b ^ BUCKET_FLIP, 16'($urandom)};
			push_request(OP_WR_VALUE, $urandom, i[ADDR_W-1:0], v);
			fresh_values.push_back(v);
		end
		live_buckets.push_back(b);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
		error_cnt++;
	endtask

	// Waits until every queued transaction has been taken and answered.
	task automatic wait_idle();
		while (request_q.size() != 0 || in_valid || expected_answers.size() != 0)
			@(negedge clk);
	endtask

	// Writes table_count while the block is idle.
	task automatic set_count(input logic [CNT_W-1:0] c);
		wait_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		table_count = c;
	endtask

	// One random phase: set the count and traffic, then mostly well-formed bucket
	// loads followed by searches, with some stray transactions mixed in.
	task automatic run_phase(input logic [CNT_W-1:0] c, input int gap, input int stall,
			input bit hold, input int n);
		int                  stop_at, pick, cnt, lo, len, maxlo, j, nq;
		logic [BUCKET_W-1:0] b;
		set_count(c);
		send_gap_pct = gap;
		rx_stall_pct = stall;
		if (hold)
			hold_req = 1'b1;
		stop_at = queued_cnt + n;
		cnt = active_count();
		while (queued_cnt < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				case ($urandom_range(9))
					0: b = '0;
					1: b = LAST_BUCKET;
					2, 3, 4: b = (live_buckets.size() > 0) ?
						live_buckets[$urandom_range(live_buckets.size() - 1)] :
						BUCKET_W'($urandom);
					default: b = BUCKET_W'($urandom);
				endcase
				pick = $urandom_range(99);
				if (pick < 90)
					len = $urandom_range(6);
				else
					len = $urandom_range(20, 7);
				if (b == LAST_BUCKET) begin
					// The last bucket runs up to the count, so load up to it.
					if (len > cnt)
						len = cnt;
					lo = cnt - len;
				end else begin
					maxlo = TABLE_DEPTH_DEF - len;
					if (cnt > 0 && $urandom_range(3) != 0)
						lo = $urandom_range(cnt - 1);
					else
						lo = $urandom_range(maxlo);
					if (lo > maxlo)
						lo = maxlo;
					// An occasional inverted range.
					if (pick < 6 && lo > 0)
						len = -1 - $urandom_range(3);
				end
				build_bucket(b, lo, len);
				nq = 1 + $urandom_range(2);
				for (j = 0; j < nq; j++) begin
					if (fresh_values.size() > 0 && $urandom_range(1) == 0)
						push_query(fresh_values[$urandom_range(fresh_values.size() - 1)]);
					else
						push_query({b ^ BUCKET_FLIP, 16'($urandom)});
				end
			end else if (pick < 70) begin
				// Search again in a bucket loaded earlier.
				if (live_buckets.size() > 0) begin
					b = live_buckets[$urandom_range(live_buckets.size() - 1)];
					push_query({b ^ BUCKET_FLIP, 16'($urandom)});
				end
			end else begin
				// Stray transactions with random fields.
				case (OP_W'($urandom))
					OP_QUERY: push_query($urandom);
					OP_WR_VALUE: push_request(OP_WR_VALUE, $urandom,
						($urandom_range(1) == 0) ?
						ADDR_W'($urandom_range(TABLE_DEPTH_DEF - 1)) : ADDR_W'($urandom),
						$urandom);
					OP_WR_DIR: push_request(OP_WR_DIR, $urandom, ADDR_W'($urandom),
						($urandom_range(1) == 0) ? $urandom : $urandom_range(8300));
					default: push_request(OP_UNUSED, $urandom, ADDR_W'($urandom), $urandom);
				endcase
			end
		end
	endtask

	// Driver: holds a transaction until the block takes it, then offers the next.
	always @(negedge clk) begin : drive_requests
		request_t r;
		if (!in_valid || accepted_cnt != taken_seen) begin
			taken_seen = accepted_cnt;
			if (arst_n && request_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
				r = request_q.pop_front();
				op <= r.op;
				key <= r.key;
				address <= r.addr;
				write_data <= r.data;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off when a phase asks for it.
	always @(negedge clk) begin : drive_stall
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// Monitor: predicts each accepted transaction and checks each accepted result.
	always @(posedge clk) begin : watch_ports
		request_t r;
		answer_t  want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				r.op = op;
				r.key = key;
				r.addr = address;
				r.data = write_data;
				expected_answers.push_back(predict_answer(r));
				accepted_cnt++;
			end
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					report_mismatch("unexpected result, status", int'(status), -1);
				end else begin
					want = expected_answers.pop_front();
					if (status !== want.status)
						report_mismatch("status", int'(status), int'(want.status));
					if (found_index !== want.index)
						report_mismatch("found_index", int'(found_index), int'(want.index));
				end
			end
		end
	end

	initial begin : stimulus
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A search before any count is set is rejected.
		push_query(32'sh8000_0000);
		set_count(13'd20);
		// Lowest bucket, with a repeated value.
		push_request(OP_WR_DIR, '0, 16'h0000, 32'sd0);
		push_request(OP_WR_DIR, '0, 16'h0001, 32'sd3);
		push_request(OP_WR_VALUE, '0, 16'd0, 32'sh8000_0005);
		push_request(OP_WR_VALUE, '0, 16'd1, 32'sh8000_0007);
		push_request(OP_WR_VALUE, '0, 16'd2, 32'sh8000_0005);
		push_query(32'sh8000_0005);
		push_query(32'sh8000_0007);
		push_query(32'sh8000_0009);
		// Last bucket: its range ends at the count.
		push_request(OP_WR_DIR, '1, LAST_BUCKET, 32'sd18);
		push_request(OP_WR_VALUE, '1, 16'd18, 32'sh7FFF_FFFF);
		push_request(OP_WR_VALUE, '1, 16'd19, 32'sh7FFF_0000);
		push_query(32'sh7FFF_FFFF);
		// Empty range, with a negative start that saturates to zero.
		push_request(OP_WR_DIR, '0, 16'h8000, 32'sh8000_0000);
		push_request(OP_WR_DIR, '0, 16'h8001, 32'sd0);
		push_query(32'sd0);
		// Inverted range, with a start that saturates to the top.
		push_request(OP_WR_DIR, '0, 16'h7FFF, 32'sh7FFF_FFFF);
		push_query(-32'sd1);
		// Range that starts past the count.
		push_request(OP_WR_DIR, '0, 16'h0002, 32'sd25);
		push_request(OP_WR_DIR, '0, 16'h0003, 32'sd30);
		push_query(32'sh8002_0000);
		// Rejected: value addresses past the table, and the unused opcode.
		push_request(OP_WR_VALUE, '0, 16'hFFFF, 32'sd0);
		push_request(OP_WR_VALUE, '0, 16'd4096, 32'sd0);
		push_request(OP_UNUSED, '1, 16'hFFFF, '1);

		// Random phases over several counts and traffic patterns.
		run_phase(13'd4096, 0, 0, 1'b0, 70);
		run_phase(13'h1FFF, 87, 0, 1'b0, 60);
		run_phase(13'd0, 0, 87, 1'b0, 40);
		run_phase(13'd1, 35, 35, 1'b0, 40);
		run_phase(CNT_W'($urandom_range(4096, 64)), 0, 0, 1'b1, 60);
		run_phase(13'd4095, 0, 87, 1'b0, 60);
		run_phase(CNT_W'($urandom), 35, 35, 1'b0, 80);
		run_phase(13'd4096, 0, 0, 1'b0, 90);

		wait_idle();
		repeat (50) @(negedge clk);
		if (error_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin : watchdog
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
